FILE: rtl/lmfls_pkg.sv
`default_nettype none
package lmfls_pkg;

    localparam int unsigned CoordW   = 24;
    localparam int unsigned DiffW    = CoordW + 1;
    localparam int unsigned SqW      = 2 * DiffW;
    localparam int unsigned RadW     = 52;
    localparam int unsigned RootW    = RadW / 2;
    localparam int unsigned LenW     = 26;
    localparam int unsigned GainW    = 16;
    localparam int unsigned StimW    = 16;
    localparam int unsigned AmtW     = GainW + StimW - 1;
    localparam int unsigned DvdW     = DiffW + AmtW;
    localparam int unsigned DvsW     = DiffW + 4;
    localparam int unsigned StepW    = 16;
    localparam int unsigned OutW     = 32;
    localparam int unsigned CntW     = 6;
    localparam int unsigned RootSteps = RootW;
    localparam int unsigned DivSteps  = DvdW;

    localparam logic [LenW-1:0] LenMax = {LenW{1'b1}};

    // segment selectors
    localparam logic [1:0] SegA   = 2'd0;
    localparam logic [1:0] SegB   = 2'd1;
    localparam logic [1:0] SegDir = 2'd2;

    // register indexes
    localparam logic [1:0] RegGain = 2'd0;
    localparam logic [1:0] RegBend = 2'd1;
    localparam logic [1:0] RegStep = 2'd2;

    typedef struct packed {
        logic       load;
        logic       sq_acc;
        logic [1:0] seg;
        logic [1:0] comp;
        logic       rt_init;
        logic       rt_step;
        logic       rt_done;
        logic       f_mul;
        logic       f_zero;
        logic       f_store;
        logic       s_init;
        logic       s_store;
        logic       div_step;
        logic       publish;
    } t_cmd;

    typedef struct packed {
        logic bend;
        logic mag_zero;
        logic out_busy;
    } t_status;

    // signed saturation of a magnitude with separate sign
    function automatic logic [OutW-1:0] sat_s32(input logic neg,
                                                input logic [DvdW-1:0] q);
        logic [DvdW:0] lim;
        logic [DvdW:0] qq;
        logic [OutW-1:0] res;
        lim = {{(DvdW-OutW+2){1'b0}}, {(OutW-1){1'b1}}};
        qq  = {1'b0, q};
        if (!neg) begin
            res = (qq > lim) ? {1'b0, {(OutW-1){1'b1}}} : q[OutW-1:0];
        end else if (qq > lim) begin
            res = {1'b1, {(OutW-1){1'b0}}};
        end else begin
            res = -q[OutW-1:0];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/lmfls_ctrl.sv
`default_nettype none
module lmfls_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire lmfls_pkg::t_status i_status,
    output lmfls_pkg::t_cmd        o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_SQ, S_RTI, S_RT, S_RTD, S_FMUL, S_FDIV, S_FST,
        S_SINIT, S_SDIV, S_SST, S_OUT
    } t_state;

    t_state r_state, n_state;
    logic [lmfls_pkg::CntW-1:0] r_cnt, n_cnt;
    logic [1:0] r_seg, n_seg;
    logic [1:0] r_comp, n_comp;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_seg   = r_seg;
        n_comp  = r_comp;
        o_cmd   = '0;
        o_cmd.seg  = r_seg;
        o_cmd.comp = r_comp;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_SQ;
                    n_seg   = lmfls_pkg::SegA;
                    n_comp  = 2'd0;
                end
            end
            S_SQ: begin
                o_cmd.sq_acc = 1'b1;
                if (r_comp == 2'd2) begin
                    n_state = S_RTI;
                    n_comp  = 2'd0;
                end else begin
                    n_comp = r_comp + 2'd1;
                end
            end
            S_RTI: begin
                o_cmd.rt_init = 1'b1;
                n_cnt   = '0;
                n_state = S_RT;
            end
            S_RT: begin
                o_cmd.rt_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == lmfls_pkg::CntW'(lmfls_pkg::RootSteps - 1)) begin
                    n_state = S_RTD;
                end
            end
            S_RTD: begin
                o_cmd.rt_done = 1'b1;
                n_state = S_SQ;
                if (r_seg == lmfls_pkg::SegA) begin
                    n_seg = i_status.bend ? lmfls_pkg::SegB : lmfls_pkg::SegDir;
                end else if (r_seg == lmfls_pkg::SegB) begin
                    n_seg = lmfls_pkg::SegDir;
                end else begin
                    n_state = S_FMUL;
                end
            end
            S_FMUL: begin
                if (i_status.mag_zero) begin
                    o_cmd.f_zero = 1'b1;
                    n_state = S_SINIT;
                end else begin
                    o_cmd.f_mul = 1'b1;
                    n_cnt   = '0;
                    n_state = S_FDIV;
                end
            end
            S_FDIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == lmfls_pkg::CntW'(lmfls_pkg::DivSteps - 1)) begin
                    n_state = S_FST;
                end
            end
            S_FST: begin
                o_cmd.f_store = 1'b1;
                if (r_comp == 2'd2) begin
                    n_state = S_SINIT;
                end else begin
                    n_comp  = r_comp + 2'd1;
                    n_state = S_FMUL;
                end
            end
            S_SINIT: begin
                o_cmd.s_init = 1'b1;
                n_cnt   = '0;
                n_state = S_SDIV;
            end
            S_SDIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == lmfls_pkg::CntW'(lmfls_pkg::DivSteps - 1)) begin
                    n_state = S_SST;
                end
            end
            S_SST: begin
                o_cmd.s_store = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_status.out_busy) begin
                    o_cmd.publish = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_seg   <= lmfls_pkg::SegA;
            r_comp  <= 2'd0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_seg   <= n_seg;
            r_comp  <= n_comp;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    // checks
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && r_state == S_IDLE) |=> o_in_stall)
        else $error("accepted item did not start work");
    a_seg_b_bend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQ && r_seg == lmfls_pkg::SegB) |-> i_status.bend)
        else $error("second segment run outside bend mode");
    a_publish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.publish |-> !i_status.out_busy)
        else $error("result published over a waiting one");

endmodule
`default_nettype wire

FILE: rtl/lmfls_dp.sv
`default_nettype none
module lmfls_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire lmfls_pkg::t_cmd               i_cmd,
    output lmfls_pkg::t_status                 o_status,
    input  wire logic [lmfls_pkg::GainW-1:0]   i_gain,
    input  wire logic                          i_bend,
    input  wire logic [lmfls_pkg::StepW-1:0]   i_step,
    input  wire logic signed [23:0]            i_prox_x,
    input  wire logic signed [23:0]            i_prox_y,
    input  wire logic signed [23:0]            i_prox_z,
    input  wire logic signed [23:0]            i_dist_x,
    input  wire logic signed [23:0]            i_dist_y,
    input  wire logic signed [23:0]            i_dist_z,
    input  wire logic signed [23:0]            i_wrap_x,
    input  wire logic signed [23:0]            i_wrap_y,
    input  wire logic signed [23:0]            i_wrap_z,
    input  wire logic signed [15:0]            i_stimulus,
    input  wire logic                          i_shift_history,
    input  wire logic                          i_reload_history,
    input  wire logic                          i_out_stall,
    output logic                               o_out_valid,
    output logic signed [31:0]                 o_force_x,
    output logic signed [31:0]                 o_force_y,
    output logic signed [31:0]                 o_force_z,
    output logic [25:0]                        o_muscle_length,
    output logic signed [31:0]                 o_muscle_speed
);

    localparam int unsigned DW = lmfls_pkg::DiffW;

    logic signed [23:0] r_prox [3];
    logic signed [23:0] r_dist [3];
    logic signed [23:0] r_wrap [3];
    logic signed [15:0] r_stim;
    logic r_shift, r_reload;

    logic [lmfls_pkg::RadW-1:0]  r_acc, r_rt_v;
    logic [27:0]                 r_rt_rem;
    logic [lmfls_pkg::RootW-1:0] r_rt_root;
    logic [lmfls_pkg::LenW:0]    r_len_acc;
    logic [DW-1:0]               r_mag;
    logic [lmfls_pkg::AmtW-1:0]  r_amt;
    logic [lmfls_pkg::DvdW-1:0]  r_dvd;
    logic [lmfls_pkg::DvsW-1:0]  r_dvs, r_rem;
    logic                        r_neg;
    logic [31:0]                 r_force [3];
    logic [31:0]                 r_speed;
    logic [lmfls_pkg::LenW-1:0]  r_prev, r_prev2;
    logic                        r_ovalid;

    // operand select and difference
    logic signed [23:0] s_a, s_b;
    logic signed [DW-1:0] s_diff;
    logic [DW-1:0] s_abs;
    always_comb begin
        case (i_cmd.seg)
            lmfls_pkg::SegA: begin
                s_a = r_prox[i_cmd.comp];
                s_b = i_bend ? r_wrap[i_cmd.comp] : r_dist[i_cmd.comp];
            end
            lmfls_pkg::SegB: begin
                s_a = r_wrap[i_cmd.comp];
                s_b = r_dist[i_cmd.comp];
            end
            default: begin
                s_a = i_bend ? r_wrap[i_cmd.comp] : r_prox[i_cmd.comp];
                s_b = r_dist[i_cmd.comp];
            end
        endcase
        s_diff = DW'(s_a) - DW'(s_b);
        s_abs  = s_diff[DW-1] ? -s_diff : s_diff;
    end

    logic [lmfls_pkg::SqW-1:0] s_sq;
    assign s_sq = s_abs * s_abs;

    // root step
    logic [29:0] s_rt_sh, s_rt_trial;
    logic        s_rt_ge;
    assign s_rt_sh    = {r_rt_rem, r_rt_v[lmfls_pkg::RadW-1 -: 2]};
    assign s_rt_trial = {2'b00, r_rt_root, 2'b01};
    assign s_rt_ge    = (s_rt_sh >= s_rt_trial);

    // divide step
    logic [lmfls_pkg::DvsW:0] s_dv_sh, s_dv_sub;
    logic                     s_dv_ge;
    assign s_dv_sh  = {r_rem, r_dvd[lmfls_pkg::DvdW-1]};
    assign s_dv_sub = s_dv_sh - {1'b0, r_dvs};
    assign s_dv_ge  = (s_dv_sh >= {1'b0, r_dvs});

    // saturated length and speed operands
    logic [lmfls_pkg::LenW-1:0] s_len, s_old;
    logic [lmfls_pkg::LenW:0]   s_sdiff;
    logic [lmfls_pkg::LenW-1:0] s_sabs;
    logic [lmfls_pkg::StepW-1:0] s_step;
    logic [lmfls_pkg::StimW-2:0] s_stim;
    assign s_len   = (r_len_acc > {1'b0, lmfls_pkg::LenMax}) ? lmfls_pkg::LenMax
                                                             : r_len_acc[lmfls_pkg::LenW-1:0];
    assign s_old   = r_reload ? s_len : r_prev2;
    assign s_sdiff = {1'b0, s_len} - {1'b0, s_old};
    assign s_sabs  = s_sdiff[lmfls_pkg::LenW] ? lmfls_pkg::LenW'(-s_sdiff)
                                              : s_sdiff[lmfls_pkg::LenW-1:0];
    assign s_step  = (i_step == '0) ? lmfls_pkg::StepW'(1) : i_step;
    assign s_stim  = r_stim[15] ? '0 : r_stim[14:0];

    // item registers and working state
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_prox[0] <= i_prox_x; r_prox[1] <= i_prox_y; r_prox[2] <= i_prox_z;
            r_dist[0] <= i_dist_x; r_dist[1] <= i_dist_y; r_dist[2] <= i_dist_z;
            r_wrap[0] <= i_wrap_x; r_wrap[1] <= i_wrap_y; r_wrap[2] <= i_wrap_z;
            r_stim    <= i_stimulus;
            r_shift   <= i_shift_history;
            r_reload  <= i_reload_history;
        end
        if (i_cmd.sq_acc) begin
            r_acc <= ((i_cmd.comp == 2'd0) ? '0 : r_acc) + lmfls_pkg::RadW'(s_sq);
            r_amt <= i_gain * s_stim;
        end
        if (i_cmd.rt_init) begin
            r_rt_v    <= r_acc;
            r_rt_rem  <= '0;
            r_rt_root <= '0;
        end else if (i_cmd.rt_step) begin
            r_rt_v   <= {r_rt_v[lmfls_pkg::RadW-3:0], 2'b00};
            r_rt_rem <= s_rt_ge ? 28'(s_rt_sh - s_rt_trial) : s_rt_sh[27:0];
            r_rt_root <= {r_rt_root[lmfls_pkg::RootW-2:0], s_rt_ge};
        end
        if (i_cmd.rt_done) begin
            case (i_cmd.seg)
                lmfls_pkg::SegA: r_len_acc <= (lmfls_pkg::LenW+1)'(r_rt_root);
                lmfls_pkg::SegB: r_len_acc <= r_len_acc + (lmfls_pkg::LenW+1)'(r_rt_root);
                default:         r_mag <= r_rt_root[DW-1:0];
            endcase
        end
        // divider loads and steps
        if (i_cmd.f_mul) begin
            r_dvd <= s_abs * r_amt;
            r_dvs <= {r_mag, 4'b0000};
            r_rem <= '0;
            r_neg <= s_diff[DW-1];
        end else if (i_cmd.s_init) begin
            r_dvd <= {{(lmfls_pkg::DvdW-lmfls_pkg::LenW-16){1'b0}}, s_sabs, 16'h0000};
            r_dvs <= {{(lmfls_pkg::DvsW-lmfls_pkg::StepW-1){1'b0}}, s_step, 1'b0};
            r_rem <= '0;
            r_neg <= s_sdiff[lmfls_pkg::LenW];
        end else if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[lmfls_pkg::DvdW-2:0], s_dv_ge};
            r_rem <= s_dv_ge ? s_dv_sub[lmfls_pkg::DvsW-1:0] : s_dv_sh[lmfls_pkg::DvsW-1:0];
        end
        if (i_cmd.f_zero) begin
            r_force[0] <= '0; r_force[1] <= '0; r_force[2] <= '0;
        end else if (i_cmd.f_store) begin
            r_force[i_cmd.comp] <= lmfls_pkg::sat_s32(r_neg, r_dvd);
        end
        if (i_cmd.s_store) begin
            r_speed <= lmfls_pkg::sat_s32(r_neg, r_dvd);
        end
        if (i_cmd.publish) begin
            o_force_x       <= r_force[0];
            o_force_y       <= r_force[1];
            o_force_z       <= r_force[2];
            o_muscle_length <= s_len;
            o_muscle_speed  <= r_speed;
        end
    end

    // length history and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev   <= '0;
            r_prev2  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.s_store) begin
                if (r_shift) begin
                    r_prev2 <= r_reload ? s_len : r_prev;
                    r_prev  <= s_len;
                end else if (r_reload) begin
                    r_prev2 <= s_len;
                    r_prev  <= s_len;
                end
            end
            if (i_cmd.publish) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_out_valid       = r_ovalid;
    assign o_status.bend     = i_bend;
    assign o_status.mag_zero = (r_mag == '0);
    assign o_status.out_busy = r_ovalid && i_out_stall;

endmodule
`default_nettype wire

FILE: rtl/linear_muscle_force_length_speed.sv
// Linear muscle force, path length and lengthening speed.
// Input channel: i_in_valid / o_in_stall carries one item (proximal, distal,
// wrap points, stimulus, history flags). Output channel: o_out_valid /
// i_out_stall carries one result (force vector, length, speed) per item.
// An item is taken when valid is high and stall is low at a clock edge.
// Configuration (gain, bend mode, time step) goes over the APB port at byte
// addresses 0, 4, 8; write it only while the block is idle.
// Work per item runs on one shared integer square root (one bit per cycle,
// run twice or three times) and one shared restoring divider (one bit per
// cycle, run for three force components and speed). Each root pass squares
// and sums the three components, loads the root, steps it and stores it;
// each division loads, steps and stores. A zero-length direction skips the
// three force divisions. One item is worked on at a time, so no new item
// is taken until the result of the last one is published.
// A result is published once the output register is free; a stalled result
// holds and keeps the next result, and so the input, waiting.
// Reset (synchronous, active low) clears the length history, the output
// valid and the controller, and returns registers to gain 1.0, straight
// mode and a time step of 655.
`default_nettype none
module linear_muscle_force_length_speed (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic signed [23:0] i_prox_x,
    input  wire logic signed [23:0] i_prox_y,
    input  wire logic signed [23:0] i_prox_z,
    input  wire logic signed [23:0] i_dist_x,
    input  wire logic signed [23:0] i_dist_y,
    input  wire logic signed [23:0] i_dist_z,
    input  wire logic signed [23:0] i_wrap_x,
    input  wire logic signed [23:0] i_wrap_y,
    input  wire logic signed [23:0] i_wrap_z,
    input  wire logic signed [15:0] i_stimulus,
    input  wire logic               i_shift_history,
    input  wire logic               i_reload_history,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic signed [31:0]      o_force_x,
    output logic signed [31:0]      o_force_y,
    output logic signed [31:0]      o_force_z,
    output logic [25:0]             o_muscle_length,
    output logic signed [31:0]      o_muscle_speed
);

    logic [lmfls_pkg::GainW-1:0] r_gain;
    logic                        r_bend;
    logic [lmfls_pkg::StepW-1:0] r_step;
    logic [1:0]                  s_idx;
    logic                        s_wr;

    assign pready = 1'b1;
    assign s_idx  = paddr[3:2];
    assign s_wr   = psel && penable && pwrite;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= lmfls_pkg::GainW'(256);
            r_bend <= 1'b0;
            r_step <= lmfls_pkg::StepW'(655);
        end else if (s_wr) begin
            case (s_idx)
                lmfls_pkg::RegGain: r_gain <= pwdata[lmfls_pkg::GainW-1:0];
                lmfls_pkg::RegBend: r_bend <= pwdata[0];
                lmfls_pkg::RegStep: r_step <= pwdata[lmfls_pkg::StepW-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (s_idx)
            lmfls_pkg::RegGain: prdata = {16'h0000, r_gain};
            lmfls_pkg::RegBend: prdata = {31'h0, r_bend};
            lmfls_pkg::RegStep: prdata = {16'h0000, r_step};
            default:            prdata = '0;
        endcase
    end

    lmfls_pkg::t_cmd    s_cmd;
    lmfls_pkg::t_status s_status;

    lmfls_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (s_status),
        .o_cmd      (s_cmd)
    );

    lmfls_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (s_cmd),
        .o_status         (s_status),
        .i_gain           (r_gain),
        .i_bend           (r_bend),
        .i_step           (r_step),
        .i_prox_x         (i_prox_x),
        .i_prox_y         (i_prox_y),
        .i_prox_z         (i_prox_z),
        .i_dist_x         (i_dist_x),
        .i_dist_y         (i_dist_y),
        .i_dist_z         (i_dist_z),
        .i_wrap_x         (i_wrap_x),
        .i_wrap_y         (i_wrap_y),
        .i_wrap_z         (i_wrap_z),
        .i_stimulus       (i_stimulus),
        .i_shift_history  (i_shift_history),
        .i_reload_history (i_reload_history),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_force_x        (o_force_x),
        .o_force_y        (o_force_y),
        .o_force_z        (o_force_z),
        .o_muscle_length  (o_muscle_length),
        .o_muscle_speed   (o_muscle_speed)
    );

    // checks
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_muscle_speed)))
        else $error("stalled result changed");
    a_reset_clear: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> (!o_out_valid && !o_in_stall))
        else $error("reset left block busy");
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_wr && s_idx == lmfls_pkg::RegBend) |-> !o_in_stall)
        else $error("bend mode written while busy");

endmodule
`default_nettype wire
